// ===== src/rfs_pkg.sv =====
// ---------------------------------------------------------------------------
// rfs_pkg
// Shared constants, types and the log2 lookup table for the rank-based
// fitness shaping block.
// ---------------------------------------------------------------------------
`default_nettype none

package rfs_pkg;

  // Batch capacity and derived widths.
  localparam int MAX_SAMPLES  = 64;
  localparam int IDX_W        = $clog2(MAX_SAMPLES);
  localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);

  // Field widths of the channels.
  localparam int REWARD_W     = 32;
  localparam int UTIL_W       = 32;
  localparam int SAMPLE_IDX_W = 6;

  // Fixed-point formats: log values are unsigned Q6.26, results Q2.30.
  localparam int LOG_FRAC     = 26;
  localparam int OUT_FRAC     = 30;
  localparam int LOG_W        = 32;
  localparam int SUM_W        = LOG_W + CNT_W;
  localparam int NUM_W        = LOG_W + OUT_FRAC + 1;

  // The log table covers 0..MAX_SAMPLES+2; entry 0 is unused and holds zero.
  localparam int LOG_DEPTH    = MAX_SAMPLES + 3;
  localparam int LOG_IDX_W    = $clog2(LOG_DEPTH);

  typedef logic [LOG_W-1:0] log_tab_t [0:LOG_DEPTH-1];

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BIAS_GO,
    ST_BIAS_WAIT,
    ST_RI_RD,
    ST_RI_CAP,
    ST_RJ,
    ST_RANK_WR,
    ST_ACC,
    ST_U_RD,
    ST_U_RAW,
    ST_U_GO,
    ST_U_WAIT,
    ST_EMIT
  } rfs_state_t;

  // log2(k) in Q6.26 by repeated squaring, each step truncating.
  function automatic log_tab_t build_log2_tab();
    log_tab_t            tab;
    logic [63:0]         y;
    logic [LOG_W-1:0]    frac;
    int                  ip;
    int                  t;
    tab[0] = '0;
    for (int k = 1; k < LOG_DEPTH; k++) begin
      t  = k;
      ip = 0;
      while (t > 1) begin
        t  = t >> 1;
        ip = ip + 1;
      end
      y    = (64'(k) << OUT_FRAC) >> ip;
      frac = '0;
      for (int i = 0; i < LOG_FRAC; i++) begin
        y = (y * y) >> OUT_FRAC;
        if (y >= (64'd2 << OUT_FRAC)) begin
          y = y >> 1;
          frac[LOG_FRAC-1-i] = 1'b1;
        end
      end
      tab[k] = (LOG_W'(ip) << LOG_FRAC) | frac;
    end
    return tab;
  endfunction

  localparam log_tab_t LOG2_TAB = build_log2_tab();

endpackage

`default_nettype wire

// ===== src/rfs_if.sv =====
// ---------------------------------------------------------------------------
// rfs_in_if / rfs_out_if
// Valid/ready channels for reward samples and shaped utilities.
// ---------------------------------------------------------------------------
`default_nettype none

interface rfs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rfs_pkg::REWARD_W-1:0] reward_value;
  logic                                last_sample;

  modport source (output valid, output reward_value, output last_sample, input ready);
  modport sink   (input valid, input reward_value, input last_sample, output ready);
endinterface

interface rfs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rfs_pkg::UTIL_W-1:0]     utility_value;
  logic        [rfs_pkg::SAMPLE_IDX_W-1:0] sample_index;
  logic                                  last_utility;

  modport source (output valid, output utility_value, output sample_index,
                  output last_utility, input ready);
  modport sink   (input valid, input utility_value, input sample_index,
                  input last_utility, output ready);
endinterface

`default_nettype wire

// ===== src/rank_fitness_shaping_unit.sv =====
// ---------------------------------------------------------------------------
// rank_fitness_shaping_unit
// Rank-based fitness shaping: loads a batch of rewards, ranks them and emits
// normalized Q2.30 utilities in sample order.
// ---------------------------------------------------------------------------
// Rewards load at one beat per cycle until the beat marked last_sample; beats
// past 64 samples are dropped but a final one still closes the batch. The
// block then stops taking input: ranking compares every pair of samples
// through the single read port of the reward RAM, and each utility then
// takes a pass through the shared serial divider plus RAM and table access,
// with one more divider pass at the start for the 1/N bias. Output beats
// leave one at a time from a held output register; input is accepted again
// after the last utility beat.
// ---------------------------------------------------------------------------
`default_nettype none

module rank_fitness_shaping_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rfs_in_if.sink      in_ch,
  rfs_out_if.source   out_ch
);
  import rfs_pkg::*;

  rfs_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       count_r;
  logic [IDX_W-1:0]       i_r;
  logic [IDX_W-1:0]       j_r;
  logic [IDX_W-1:0]       rank_r;
  logic [IDX_W-1:0]       last_idx;
  logic [REWARD_W-1:0]    ref_r;
  logic [SUM_W-1:0]       sum_r;
  logic [LOG_W-1:0]       raw_r;
  logic [UTIL_W-1:0]      bias_r;
  logic [UTIL_W-1:0]      util_r;
  logic                   out_valid_r;
  logic                   out_last_r;
  logic [IDX_W-1:0]       out_idx_r;

  logic                   in_acc;
  logic                   out_acc;
  logic                   store_we;
  logic [IDX_W-1:0]       rew_raddr;
  logic [REWARD_W-1:0]    rew_rdata;
  logic                   rank_we;
  logic [IDX_W-1:0]       rank_rdata;
  logic                   hit;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [NUM_W-1:0]       div_num;
  logic [SUM_W-1:0]       div_den;
  logic [NUM_W-1:0]       div_quo;
  logic [LOG_W-1:0]       log_top;
  logic [LOG_W-1:0]       log_sub;
  logic [LOG_W-1:0]       raw_val;
  logic [IDX_W-1:0]       raw_rank;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign last_idx = IDX_W'(count_r - 1'b1);

  // Pair compare: sample j ranks ahead of sample i.
  assign hit = ($signed(rew_rdata) > $signed(ref_r)) ||
               ((j_r < i_r) && (rew_rdata == ref_r));

  // Raw utility from the log table for the rank in hand.
  assign raw_rank = (state_r == ST_RANK_WR) ? rank_r : rank_rdata;
  assign log_top  = LOG2_TAB[LOG_IDX_W'(count_r) + LOG_IDX_W'(2)];
  assign log_sub  = (LOG_W'(1) << LOG_FRAC) + LOG2_TAB[LOG_IDX_W'(raw_rank) + LOG_IDX_W'(1)];
  assign raw_val  = (log_top > log_sub) ? (log_top - log_sub) : '0;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (in_acc && in_ch.last_sample) state_nxt = ST_BIAS_GO;
      ST_BIAS_GO:   state_nxt = ST_BIAS_WAIT;
      ST_BIAS_WAIT: if (div_done) state_nxt = ST_RI_RD;
      ST_RI_RD:     state_nxt = ST_RI_CAP;
      ST_RI_CAP:    state_nxt = ST_RJ;
      ST_RJ:        if (j_r == last_idx) state_nxt = ST_RANK_WR;
      ST_RANK_WR:   state_nxt = ST_ACC;
      ST_ACC:       state_nxt = (i_r == last_idx) ? ST_U_RD : ST_RI_RD;
      ST_U_RD:      state_nxt = ST_U_RAW;
      ST_U_RAW:     state_nxt = ST_U_GO;
      ST_U_GO:      state_nxt = ST_U_WAIT;
      ST_U_WAIT:    if (div_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) begin
          state_nxt = out_last_r ? ST_LOAD : ST_U_RD;
        end
      end
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    store_we    = 1'b0;
    rank_we     = 1'b0;
    div_start   = 1'b0;
    rew_raddr   = i_r;
    div_num     = (NUM_W'(raw_r) << OUT_FRAC) + NUM_W'(sum_r >> 1);
    div_den     = sum_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        store_we    = in_ch.valid && (count_r != CNT_W'(MAX_SAMPLES));
      end
      ST_BIAS_GO: begin
        div_start = 1'b1;
        div_num   = (NUM_W'(1) << OUT_FRAC) + NUM_W'(count_r >> 1);
        div_den   = SUM_W'(count_r);
      end
      ST_RI_CAP:  rew_raddr = '0;
      ST_RJ:      rew_raddr = j_r + 1'b1;
      ST_RANK_WR: rank_we   = 1'b1;
      ST_U_GO:    div_start = 1'b1;
      default: begin
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_BIAS_WAIT: if (div_done) bias_r <= div_quo[UTIL_W-1:0];
      ST_RI_CAP: begin
        ref_r  <= rew_rdata;
        j_r    <= '0;
        rank_r <= '0;
      end
      ST_RJ: begin
        j_r    <= j_r + 1'b1;
        rank_r <= rank_r + IDX_W'(hit);
      end
      ST_RANK_WR: raw_r <= raw_val;
      ST_U_RAW:   raw_r <= raw_val;
      ST_U_WAIT: begin
        if (div_done) begin
          util_r     <= div_quo[UTIL_W-1:0] - bias_r;
          out_idx_r  <= i_r;
          out_last_r <= (i_r == last_idx);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers: sample count, running sum, sample pointer, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc && (count_r != CNT_W'(MAX_SAMPLES))) begin
            count_r <= count_r + 1'b1;
          end
          i_r   <= '0;
          sum_r <= '0;
        end
        ST_ACC: begin
          sum_r <= sum_r + SUM_W'(raw_r);
          i_r   <= (i_r == last_idx) ? '0 : i_r + 1'b1;
        end
        ST_U_WAIT: if (div_done) out_valid_r <= 1'b1;
        ST_EMIT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            i_r         <= i_r + 1'b1;
            if (out_last_r) begin
              count_r <= '0;
              sum_r   <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  rfs_ram #(.WIDTH(REWARD_W), .DEPTH(MAX_SAMPLES)) u_reward_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_ch.reward_value),
    .raddr (rew_raddr),
    .rdata (rew_rdata)
  );

  rfs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SAMPLES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (i_r),
    .wdata (rank_r),
    .raddr (i_r),
    .rdata (rank_rdata)
  );

  rfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.utility_value = util_r;
  assign out_ch.sample_index  = SAMPLE_IDX_W'(out_idx_r);
  assign out_ch.last_utility  = out_last_r;

  // A result beat is only offered while a batch is loaded.
  a_out_batch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> count_r != '0) else $error("utility beat with empty batch");

  // The divider only reports completion while the sequencer waits on it.
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_BIAS_WAIT || state_r == ST_U_WAIT))
    else $error("divider result not consumed");

  // Utility division always sees a nonzero sum of raw utilities.
  a_sum_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_U_GO |-> sum_r != '0) else $error("zero utility sum");

  // Input stays blocked while the divider is running.
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_ch.ready) else $error("input taken during processing");

endmodule

`default_nettype wire

// ===== src/rfs_ram.sv =====
// ---------------------------------------------------------------------------
// rfs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rfs_div.sv =====
// ---------------------------------------------------------------------------
// rfs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rfs_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rfs_pkg::NUM_W-1:0]  num,
  input  wire logic [rfs_pkg::SUM_W-1:0]  den,
  output logic                            busy,
  output logic                            done,
  output logic      [rfs_pkg::NUM_W-1:0]  quo
);
  import rfs_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [SUM_W:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W+1:0]  trial;

  // One shift-subtract step per cycle, most significant bit first.
  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]} - {2'b00, den_r};
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      quo_nxt  = '0;
      rem_nxt  = '0;
      step_nxt = STEP_W'(NUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (!trial[SUM_W+1]) begin
        rem_nxt = trial[SUM_W:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[SUM_W-1:0], num_r[NUM_W-1]};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  // A start is only issued to an idle divider.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

  // Done comes exactly once, at the end of a run.
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without a finished run");

  // A running divider never sees a zero divisor.
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> den_r != '0) else $error("division by zero");

endmodule

`default_nettype wire
